// File: rtl/cfl_pkg.sv
// Shared types and constants for the chained chunk free-list manager.
// Depends on nothing; every other file of the block but cfl_stream_if uses it by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package cfl_pkg;

  localparam int FIELD_W = 11;

  typedef logic [FIELD_W-1:0] field_t;

  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

  typedef enum logic {
    STAT_OK    = 1'b0,
    STAT_SHORT = 1'b1
  } status_t;

  typedef struct packed {
    func_t  func;
    field_t chunk_count;
    field_t chain_head;
  } req_t;

  typedef struct packed {
    status_t status;
    field_t  head_index;
    field_t  free_left;
  } rsp_t;

  // Port strobes from the sequencer to the link table.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ram_ctl_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_RESULT
  } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/cfl_stream_if.sv
// Valid/ready channel carrying one word of a chosen payload type.
// Used with cfl_pkg::req_t and cfl_pkg::rsp_t payloads.
`timescale 1ns / 1ps
`default_nettype none

interface cfl_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: rtl/cfl_link_ram.sv
// Next-link table: one write port and one registered read port.
// A read of the address written in the same cycle returns the new data.
`timescale 1ns / 1ps
`default_nettype none

module cfl_link_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 11
) (
  input  wire logic              clk,
  input  wire cfl_pkg::ram_ctl_t ctl,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/cfl_seq.sv
// Sequencer: walks the link table one chunk per cycle for alloc and free,
// keeps free head and free count, and holds the result word.
// Depends on cfl_pkg, cfl_stream_if; drives the cfl_link_ram ports.
`timescale 1ns / 1ps
`default_nettype none

module cfl_seq #(
  parameter int NUM_CHUNKS = 1024,
  parameter int ADDR_W     = 10,
  parameter int IDX_W      = 11,
  parameter int CMP_W      = 11
) (
  input  wire logic               clk,
  input  wire logic               rst,
  cfl_stream_if.sink              req,
  cfl_stream_if.source            rsp,
  output cfl_pkg::ram_ctl_t       ram_ctl,
  output logic       [ADDR_W-1:0] rd_addr,
  output logic       [ADDR_W-1:0] wr_addr,
  output logic       [IDX_W-1:0]  wr_data,
  input  wire logic  [IDX_W-1:0]  rd_data
);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam idx_t  NONE_IDX   = idx_t'(NUM_CHUNKS);
  localparam idx_t  LAST_IDX   = idx_t'(NUM_CHUNKS - 1);
  localparam addr_t LAST_ADDR  = addr_t'(NUM_CHUNKS - 1);
  localparam cmp_t  NONE_CMP   = cmp_t'(NUM_CHUNKS);

  cfl_pkg::seq_state_t state, state_next;
  addr_t               init_addr, init_addr_next;
  idx_t                free_head, free_head_next;
  idx_t                free_cnt, free_cnt_next;
  cfl_pkg::field_t     remaining, remaining_next;
  idx_t                chain, chain_next;
  cmp_t                cur, cur_next;
  idx_t                steps, steps_next;
  logic                waiting, waiting_next;
  cfl_pkg::status_t    status, status_next;
  logic                out_valid, out_valid_next;
  cfl_pkg::rsp_t       out_word, out_word_next;

  assign req.ready   = (state == cfl_pkg::ST_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cfl_pkg::ST_INIT;
      init_addr <= '0;
      free_head <= LAST_IDX;
      free_cnt  <= NONE_IDX;
      waiting   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      init_addr <= init_addr_next;
      free_head <= free_head_next;
      free_cnt  <= free_cnt_next;
      waiting   <= waiting_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    chain     <= chain_next;
    cur       <= cur_next;
    steps     <= steps_next;
    status    <= status_next;
    out_word  <= out_word_next;
  end

  always_comb begin
    state_next      = state;
    init_addr_next  = init_addr;
    free_head_next  = free_head;
    free_cnt_next   = free_cnt;
    remaining_next  = remaining;
    chain_next      = chain;
    cur_next        = cur;
    steps_next      = steps;
    waiting_next    = waiting;
    status_next     = status;
    out_valid_next  = out_valid;
    out_word_next   = out_word;
    ram_ctl         = '0;
    rd_addr         = '0;
    wr_addr         = '0;
    wr_data         = '0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      cfl_pkg::ST_INIT: begin
        // Rebuild the descending free list, one entry per cycle.
        ram_ctl.wr_en  = 1'b1;
        wr_addr        = init_addr;
        wr_data        = (init_addr == '0) ? NONE_IDX : idx_t'(init_addr) - 1'b1;
        init_addr_next = init_addr + 1'b1;
        if (init_addr == LAST_ADDR) begin
          state_next = cfl_pkg::ST_IDLE;
        end
      end

      cfl_pkg::ST_IDLE: begin
        if (req.valid) begin
          chain_next   = NONE_IDX;
          waiting_next = 1'b0;
          steps_next   = '0;
          status_next  = cfl_pkg::STAT_OK;
          if (req.payload.func == cfl_pkg::FUNC_ALLOC) begin
            remaining_next = req.payload.chunk_count;
            if (cmp_t'(req.payload.chunk_count) > cmp_t'(free_cnt)) begin
              status_next = cfl_pkg::STAT_SHORT;
              state_next  = cfl_pkg::ST_RESULT;
            end else if (req.payload.chunk_count == '0) begin
              state_next = cfl_pkg::ST_RESULT;
            end else begin
              state_next = cfl_pkg::ST_ALLOC;
            end
          end else begin
            cur_next   = cmp_t'(req.payload.chain_head);
            state_next = cfl_pkg::ST_FREE;
          end
        end
      end

      cfl_pkg::ST_ALLOC: begin
        if (!waiting) begin
          if (free_head >= NONE_IDX) begin
            // List ran dry before the count was reached.
            free_cnt_next = '0;
            state_next    = cfl_pkg::ST_RESULT;
          end else begin
            ram_ctl.rd_en = 1'b1;
            rd_addr       = free_head[ADDR_W-1:0];
            waiting_next  = 1'b1;
          end
        end else begin
          // Pop: link the node to the chain built so far.
          ram_ctl.wr_en  = 1'b1;
          wr_addr        = free_head[ADDR_W-1:0];
          wr_data        = chain;
          chain_next     = free_head;
          free_head_next = rd_data;
          free_cnt_next  = free_cnt - 1'b1;
          remaining_next = remaining - 1'b1;
          if (remaining == cfl_pkg::field_t'(1)) begin
            waiting_next = 1'b0;
            state_next   = cfl_pkg::ST_RESULT;
          end else if (rd_data < NONE_IDX) begin
            ram_ctl.rd_en = 1'b1;
            rd_addr       = rd_data[ADDR_W-1:0];
          end else begin
            waiting_next = 1'b0;
          end
        end
      end

      cfl_pkg::ST_FREE: begin
        if (!waiting) begin
          if (cur >= NONE_CMP || steps == NONE_IDX) begin
            state_next = cfl_pkg::ST_RESULT;
          end else begin
            ram_ctl.rd_en = 1'b1;
            rd_addr       = cur[ADDR_W-1:0];
            waiting_next  = 1'b1;
          end
        end else begin
          // Push the current chunk onto the free head.
          ram_ctl.wr_en  = 1'b1;
          wr_addr        = cur[ADDR_W-1:0];
          wr_data        = free_head;
          free_head_next = cur[IDX_W-1:0];
          if (free_cnt != NONE_IDX) begin
            free_cnt_next = free_cnt + 1'b1;
          end
          steps_next = steps + 1'b1;
          cur_next   = cmp_t'(rd_data);
          if (rd_data < NONE_IDX && steps != LAST_IDX) begin
            ram_ctl.rd_en = 1'b1;
            rd_addr       = rd_data[ADDR_W-1:0];
          end else begin
            waiting_next = 1'b0;
          end
        end
      end

      cfl_pkg::ST_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next           = 1'b1;
          out_word_next.status     = status;
          out_word_next.head_index = cfl_pkg::field_t'(chain);
          out_word_next.free_left  = cfl_pkg::field_t'(free_cnt);
          state_next               = cfl_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = cfl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/chained_chunk_free_list_manager.sv
// Top level of the chained chunk free-list manager: sequencer plus link table.
// Depends on cfl_pkg, cfl_stream_if, cfl_seq and cfl_link_ram.
//
//   channel  dir  word                                     handshake
//   req      in   func, chunk_count, chain_head (req_t)    valid/ready
//   rsp      out  status, head_index, free_left (rsp_t)    valid/ready
//
// After rst the link table is rebuilt, one entry a cycle, and req.ready stays low
// until the rebuild is done. One request at a time: an alloc or a free walks the
// chain one chunk per cycle over the single link-table port pair, and a shortage
// or a zero count goes straight to the result.
// A result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module chained_chunk_free_list_manager #(
  parameter int NUM_CHUNKS = 1024
) (
  input  wire logic    clk,
  input  wire logic    rst,
  cfl_stream_if.sink   req,
  cfl_stream_if.source rsp
);

  localparam int ADDR_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int IDX_W  = $clog2(NUM_CHUNKS + 1);
  localparam int CMP_W  = (IDX_W > cfl_pkg::FIELD_W) ? IDX_W : cfl_pkg::FIELD_W;

  cfl_pkg::ram_ctl_t ram_ctl;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [IDX_W-1:0]  wr_data;
  logic [IDX_W-1:0]  rd_data;

  cfl_seq #(
    .NUM_CHUNKS (NUM_CHUNKS),
    .ADDR_W     (ADDR_W),
    .IDX_W      (IDX_W),
    .CMP_W      (CMP_W)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .ram_ctl (ram_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  cfl_link_ram #(
    .DEPTH  (NUM_CHUNKS),
    .ADDR_W (ADDR_W),
    .DATA_W (IDX_W)
  ) u_link_ram (
    .clk     (clk),
    .ctl     (ram_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// File: rtl/cfl_checker.sv
// Port-level checks for the chained chunk free-list manager, bound to the top.
// Depends on cfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cfl_checker #(
  parameter int NUM_CHUNKS = 1024
) (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire cfl_pkg::rsp_t rsp_payload
);

  localparam cfl_pkg::field_t NONE_FIELD = cfl_pkg::field_t'(NUM_CHUNKS);

  // The table rebuild holds off requests right after reset.
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready)
    else $error("request taken during table rebuild");

  // One request in flight: ready drops after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while busy");

  a_short_no_head: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_payload.status == cfl_pkg::STAT_SHORT) |->
      (rsp_payload.head_index == NONE_FIELD))
    else $error("shortage result carries a chain head");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
    else $error("stalled result word changed or dropped");

endmodule

bind chained_chunk_free_list_manager cfl_checker #(
  .NUM_CHUNKS (NUM_CHUNKS)
) u_cfl_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

`default_nettype wire
